### design/pcc_pkg.sv
package pcc_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 31;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_OUTPUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_INTEGRAL = 3'd4;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
    localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 31'h7FFF_FFFF;

    // step count of the last quotient bit below the saturation point
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd30;

    typedef struct packed {
        logic signed [31:0] measured;
        logic signed [31:0] setpoint;
        logic [15:0]        period;
    } t_in;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               integral_clamped;
        logic               output_clamped;
    } t_out;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] gain_p;
        logic [CFG_DATA_W-1:0] gain_i;
        logic [CFG_DATA_W-1:0] gain_d;
        logic [CFG_DATA_W-1:0] limit_output;
        logic [CFG_DATA_W-1:0] limit_integral;
    } t_cfg;

    typedef enum logic [1:0] {
        MUL_INC,
        MUL_P,
        MUL_D,
        MUL_I
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     calc_err;
        logic     calc_diff;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     upd_int;
        logic     take_p;
        logic     take_d;
        logic     div_init;
        logic     div_step;
        logic     calc_sum;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_INC,
        S_INT,
        S_P,
        S_D,
        S_DSET,
        S_DIV,
        S_SUM,
        S_OUT
    } t_state;

    function automatic logic signed [31:0] f_sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647) begin
            r = SAT_MAX;
        end else if (v < -48'sd2147483648) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### design/pcc_ctrl.sv
module pcc_ctrl
    import pcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.mul_sel = MUL_INC;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state = S_INC;
            end
            S_INC: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = MUL_INC;
                o_cmd.calc_diff = 1'b1;
                n_state = S_INT;
            end
            S_INT: begin
                o_cmd.upd_int = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = MUL_P;
                n_state = S_P;
            end
            S_P: begin
                o_cmd.take_p = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = MUL_D;
                n_state = S_D;
            end
            S_D: begin
                o_cmd.take_d = 1'b1;
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = MUL_I;
                n_state = S_DSET;
            end
            S_DSET: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.calc_sum = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/pcc_dpath.sv
module pcc_dpath
    import pcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_in   i_in,
    input  t_cfg  i_cfg,
    output t_stat o_stat,
    output t_out  o_res
);

    logic signed [31:0] r_meas;
    logic signed [31:0] r_setp;
    logic [15:0]        r_per;
    logic signed [31:0] r_err;
    logic signed [31:0] r_prev;
    logic signed [31:0] r_diff;
    logic signed [31:0] r_integral;
    logic               r_int_hit;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_p;
    logic signed [31:0] r_d;
    logic               r_neg;
    logic               r_sat;
    logic [15:0]        r_rem;
    logic [30:0]        r_mag_lo;
    logic [30:0]        r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic signed [31:0] r_drive;
    logic               r_out_hit;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [32:0] err_full;
    logic signed [32:0] diff_full;
    logic signed [32:0] int_sum;
    logic signed [32:0] lim_i;
    logic [15:0]        divisor;
    logic [61:0]        mag;
    logic [30:0]        mag_hi;
    logic [16:0]        trial;
    logic signed [31:0] i_term;
    logic signed [33:0] drv_sum;
    logic signed [33:0] lim_o;

    // shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_INC: begin
                mul_a = r_err;
                mul_b = $signed({16'b0, r_per});
            end
            MUL_P: begin
                mul_a = $signed({1'b0, i_cfg.gain_p});
                mul_b = r_err;
            end
            MUL_D: begin
                mul_a = $signed({1'b0, i_cfg.gain_d});
                mul_b = r_diff;
            end
            MUL_I: begin
                mul_a = $signed({1'b0, i_cfg.gain_i});
                mul_b = r_integral;
            end
            default: begin
                mul_a = r_err;
                mul_b = r_err;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign err_full = $signed({r_setp[31], r_setp}) - $signed({r_meas[31], r_meas});
    assign diff_full = $signed({r_err[31], r_err}) - $signed({r_prev[31], r_prev});

    // integral update, increment is floor(err * period / 2^16)
    assign int_sum = $signed({r_integral[31], r_integral})
                   + $signed({r_prod[47], r_prod[47:16]});
    assign lim_i = $signed({2'b00, i_cfg.limit_integral});

    assign divisor = (r_per == 16'd0) ? 16'd1 : r_per;
    assign mag = r_prod[63] ? 62'(-r_prod) : r_prod[61:0];
    assign mag_hi = mag[61:31];
    assign trial = {r_rem, r_mag_lo[30]};

    always_comb begin
        if (r_sat) begin
            i_term = r_neg ? SAT_MIN : SAT_MAX;
        end else if (r_neg) begin
            i_term = -$signed({1'b0, r_quo});
        end else begin
            i_term = $signed({1'b0, r_quo});
        end
    end

    assign drv_sum = 34'(r_p) + 34'(i_term) + 34'(r_d);
    assign lim_o = $signed({3'b000, i_cfg.limit_output});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_integral <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.calc_diff) begin
                r_prev <= r_err;
            end
            if (i_cmd.upd_int) begin
                if (int_sum > lim_i) begin
                    r_integral <= lim_i[31:0];
                end else if (int_sum < -lim_i) begin
                    r_integral <= 32'(-lim_i);
                end else begin
                    r_integral <= int_sum[31:0];
                end
            end
            if (i_cmd.div_init) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_meas <= i_in.measured;
            r_setp <= i_in.setpoint;
            r_per <= i_in.period;
        end
        if (i_cmd.calc_err) begin
            r_err <= f_sat32(48'(err_full));
        end
        if (i_cmd.calc_diff) begin
            r_diff <= f_sat32(48'(diff_full));
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.upd_int) begin
            r_int_hit <= (int_sum > lim_i) || (int_sum < -lim_i);
        end
        if (i_cmd.take_p) begin
            r_p <= f_sat32($signed(r_prod[63:16]));
        end
        if (i_cmd.take_d) begin
            r_d <= f_sat32($signed(r_prod[63:16]));
        end
        // quotient of at least 2^31 saturates, else 31 restoring steps
        if (i_cmd.div_init) begin
            r_neg <= r_prod[63];
            r_sat <= (mag_hi >= {15'b0, divisor});
            r_rem <= mag_hi[15:0];
            r_mag_lo <= mag[30:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_mag_lo <= {r_mag_lo[29:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                r_rem <= 16'(trial - {1'b0, divisor});
                r_quo <= {r_quo[29:0], 1'b1};
            end else begin
                r_rem <= trial[15:0];
                r_quo <= {r_quo[29:0], 1'b0};
            end
        end
        if (i_cmd.calc_sum) begin
            if (drv_sum > lim_o) begin
                r_drive <= lim_o[31:0];
                r_out_hit <= 1'b1;
            end else if (drv_sum < -lim_o) begin
                r_drive <= 32'(-lim_o);
                r_out_hit <= 1'b1;
            end else begin
                r_drive <= drv_sum[31:0];
                r_out_hit <= 1'b0;
            end
        end
    end

    assign o_stat.div_done = (r_cnt == DIV_LAST);

    assign o_res.drive = r_drive;
    assign o_res.integral_clamped = r_int_hit;
    assign o_res.output_clamped = r_out_hit;

endmodule

### design/pid_controller_clamped_core.sv
// channel | dir | signals                       | beat
// in      | in  | i_in_valid, o_in_stall, i_in  | measured, setpoint, period
// out     | out | o_out_valid, i_out_stall, o_out | drive, integral_clamped, output_clamped
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data | one register write
//
// one beat at a time: accept, error, four multiply/update steps, divider setup, a
// 31-step restoring divider for the integral term, final sum and clamp, output load
// the shared 32x32 multiplier and the one-bit-per-cycle divider set the rate
// synchronous active-low reset clears integral, last error and all control
// a finished result waits in the output register; a stalled output holds the
// controller only once the next result is ready
module pid_controller_clamped_core
    import pcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_out  r_out;
    logic  r_out_valid;
    t_cmd  cmd;
    t_stat stat;
    t_out  res;
    logic  out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p <= '0;
            r_cfg.gain_i <= '0;
            r_cfg.gain_d <= '0;
            r_cfg.limit_output <= LIMIT_RESET;
            r_cfg.limit_integral <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN_P: begin
                    r_cfg.gain_p <= i_cfg_data;
                end
                REG_GAIN_I: begin
                    r_cfg.gain_i <= i_cfg_data;
                end
                REG_GAIN_D: begin
                    r_cfg.gain_d <= i_cfg_data;
                end
                REG_LIMIT_OUTPUT: begin
                    r_cfg.limit_output <= i_cfg_data;
                end
                REG_LIMIT_INTEGRAL: begin
                    r_cfg.limit_integral <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load_out) begin
            r_out <= res;
        end
    end

    pcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    pcc_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .o_stat  (stat),
        .o_res   (res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset left the block busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote an untaken result");

endmodule
